// File: rtl/core/shelf_atlas_packer_core_defines.svh
// assertion macros for the shelf atlas packer core
// depends on clk and rst_n being visible in the module that uses them
`ifndef SHELF_ATLAS_PACKER_CORE_DEFINES_SVH
`define SHELF_ATLAS_PACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sap_pkg.sv
// shared types and constants for the shelf atlas packer
// no dependencies
package sap_pkg;

    localparam int unsigned MAX_RECTS = 8192;
    localparam int unsigned MAX_SIDE  = 2048;
    localparam int unsigned MIN_SIDE  = 16;

    localparam int unsigned IDX_W   = $clog2(MAX_RECTS);
    localparam int unsigned CNT_W   = IDX_W + 1;
    localparam int unsigned DIM_W   = 12;
    localparam int unsigned SIDE_W  = 12;
    localparam int unsigned POS_W   = 11;
    localparam int unsigned ARITH_W = DIM_W + 2;
    localparam int unsigned SIZE_W  = 2 * DIM_W;
    localparam int unsigned PLC_W   = 2 * POS_W;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_PACK   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } sap_op_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOFIT     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } sap_status_e;

    typedef struct packed {
        logic [1:0]       operation;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [IDX_W-1:0] rect_index;
    } sap_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [SIDE_W-1:0] atlas_side;
        logic [SIDE_W-1:0] atlas_height;
        logic [CNT_W-1:0]  rect_count;
    } sap_rsp_t;

endpackage

// File: rtl/core/sap_cmd_if.sv
// command channel: valid/ready plus one command item
// depends on sap_pkg
interface sap_cmd_if;
    import sap_pkg::*;

    logic     valid;
    logic     ready;
    sap_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sap_rsp_if.sv
// response channel: valid/ready plus one result item
// depends on sap_pkg
interface sap_rsp_if;
    import sap_pkg::*;

    logic     valid;
    logic     ready;
    sap_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sap_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module sap_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/shelf_atlas_packer_core.sv
// shelf atlas packer: rectangle size store, shelf packer, placement read-back
// depends on sap_pkg, sap_cmd_if, sap_rsp_if, sap_ram, shelf_atlas_packer_core_defines.svh
//
//   channel | dir | payload
//   cmd     | in  | operation, rect_width, rect_height, rect_index
//   rsp     | out | status, pos_x, pos_y, atlas_side, atlas_height, rect_count
//
// append, clear and rejected reads answer straight from idle; an accepted read waits in S_RD_WAIT for the placement ram
// pack: sides are tried in turn, one rectangle per cycle
//   through the size ram read port; a side is abandoned on its first misfit
// cmd is held off while a command is in progress or an unsent result blocks rsp
// reset clears count and pack state; ram contents are not cleared
`include "shelf_atlas_packer_core_defines.svh"

module shelf_atlas_packer_core (
    input  logic      clk,
    input  logic      rst_n,
    sap_cmd_if.sink   cmd,
    sap_rsp_if.source rsp
);
    import sap_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_PK_RUN,
        S_PK_DONE
    } state_t;

    state_t             state_reg,     state_next;
    logic [CNT_W-1:0]   count_reg,     count_next;
    logic               packed_reg,    packed_next;
    logic [SIDE_W-1:0]  chosen_side_reg,   chosen_side_next;
    logic [SIDE_W-1:0]  chosen_height_reg, chosen_height_next;
    logic [SIDE_W-1:0]  side_reg,      side_next;
    logic [CNT_W-1:0]   rd_idx_reg,    rd_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg,    wr_idx_next;
    logic               stage_vld_reg, stage_vld_next;
    logic [SIDE_W-1:0]  px_reg,        px_next;
    logic [SIDE_W-1:0]  py_reg,        py_next;
    logic [SIDE_W-1:0]  shelf_reg,     shelf_next;
    logic [SIDE_W-1:0]  used_reg,      used_next;
    logic               out_valid_reg, out_valid_next;
    sap_rsp_t           out_data_reg,  out_data_next;

    logic               size_we;
    logic [IDX_W-1:0]   size_waddr;
    logic [SIZE_W-1:0]  size_wdata;
    logic [IDX_W-1:0]   size_raddr;
    logic [SIZE_W-1:0]  size_rdata;
    logic               plc_we;
    logic [IDX_W-1:0]   plc_waddr;
    logic [PLC_W-1:0]   plc_wdata;
    logic [IDX_W-1:0]   plc_raddr;
    logic [PLC_W-1:0]   plc_rdata;

    logic               cmd_fire;
    logic               rsp_fire;

    // one rectangle of the running side
    logic [ARITH_W-1:0] w_ext, h_ext, side_ext, px_ext, py_ext, shelf_ext;
    logic [ARITH_W-1:0] px_eff, py_eff, shelf_eff;
    logic               too_big, wrap, overflow, misfit;

    function automatic logic [SIDE_W-1:0] pow2_ceil(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] vm1;
        logic [SIDE_W-1:0] r;
        vm1 = v - 1'b1;
        r   = SIDE_W'(1);
        for (int b = 0; b < SIDE_W - 1; b++)
        begin
            if (vm1[b])
            begin
                r = SIDE_W'(1) << (b + 1);
            end
        end
        if (v <= SIDE_W'(1))
        begin
            r = SIDE_W'(1);
        end
        if (vm1[SIDE_W-1] || r > SIDE_W'(MAX_SIDE))
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        return r;
    endfunction

    sap_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_RECTS)
    ) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .waddr (size_waddr),
        .wdata (size_wdata),
        .raddr (size_raddr),
        .rdata (size_rdata)
    );

    sap_ram #(
        .WIDTH (PLC_W),
        .DEPTH (MAX_RECTS)
    ) u_plc_ram (
        .clk   (clk),
        .we    (plc_we),
        .waddr (plc_waddr),
        .wdata (plc_wdata),
        .raddr (plc_raddr),
        .rdata (plc_rdata)
    );

    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp_fire  = out_valid_reg && rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    assign w_ext     = ARITH_W'(size_rdata[SIZE_W-1:DIM_W]);
    assign h_ext     = ARITH_W'(size_rdata[DIM_W-1:0]);
    assign side_ext  = ARITH_W'(side_reg);
    assign px_ext    = ARITH_W'(px_reg);
    assign py_ext    = ARITH_W'(py_reg);
    assign shelf_ext = ARITH_W'(shelf_reg);

    assign too_big   = (w_ext + ARITH_W'(1) > side_ext) || (h_ext + ARITH_W'(1) > side_ext);
    // shelf closes when the rectangle does not fit in the remaining width
    assign wrap      = (px_ext + w_ext + ARITH_W'(1) > side_ext);
    assign px_eff    = wrap ? ARITH_W'(1) : px_ext;
    assign py_eff    = wrap ? (py_ext + shelf_ext + ARITH_W'(1)) : py_ext;
    assign shelf_eff = wrap ? '0 : shelf_ext;
    assign overflow  = (py_eff + h_ext + ARITH_W'(1) > side_ext);
    assign misfit    = too_big || overflow;

    always_comb
    begin
        logic              emit;
        logic [1:0]        status;
        logic [SIDE_W-1:0] pow;

        state_next         = state_reg;
        count_next         = count_reg;
        packed_next        = packed_reg;
        chosen_side_next   = chosen_side_reg;
        chosen_height_next = chosen_height_reg;
        side_next          = side_reg;
        rd_idx_next        = rd_idx_reg;
        wr_idx_next        = wr_idx_reg;
        stage_vld_next     = stage_vld_reg;
        px_next            = px_reg;
        py_next            = py_reg;
        shelf_next         = shelf_reg;
        used_next          = used_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;

        emit   = 1'b0;
        status = ST_OK;
        pow    = pow2_ceil(used_reg);

        size_we    = 1'b0;
        size_waddr = count_reg[IDX_W-1:0];
        size_wdata = {cmd.data.rect_width, cmd.data.rect_height};
        size_raddr = rd_idx_reg[IDX_W-1:0];
        plc_we     = 1'b0;
        plc_waddr  = wr_idx_reg;
        plc_wdata  = {px_eff[POS_W-1:0], py_eff[POS_W-1:0]};
        plc_raddr  = cmd.data.rect_index;

        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.data.operation)
                        OP_APPEND:
                        begin
                            emit = 1'b1;
                            if (count_reg == CNT_W'(MAX_RECTS))
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                size_we = 1'b1;
                                // degenerate sizes become 1x1
                                if (cmd.data.rect_width == '0 || cmd.data.rect_height == '0)
                                begin
                                    size_wdata = {DIM_W'(1), DIM_W'(1)};
                                end
                                count_next         = count_reg + CNT_W'(1);
                                packed_next        = 1'b0;
                                chosen_side_next   = '0;
                                chosen_height_next = '0;
                            end
                        end
                        OP_PACK:
                        begin
                            packed_next        = 1'b0;
                            chosen_side_next   = '0;
                            chosen_height_next = '0;
                            side_next          = SIDE_W'(MIN_SIDE);
                            rd_idx_next        = '0;
                            stage_vld_next     = 1'b0;
                            px_next            = SIDE_W'(1);
                            py_next            = SIDE_W'(1);
                            shelf_next         = '0;
                            state_next         = S_PK_RUN;
                        end
                        OP_READ:
                        begin
                            if (!packed_reg || CNT_W'(cmd.data.rect_index) >= count_reg)
                            begin
                                emit   = 1'b1;
                                status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            emit               = 1'b1;
                            count_next         = '0;
                            packed_next        = 1'b0;
                            chosen_side_next   = '0;
                            chosen_height_next = '0;
                        end
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                out_valid_next             = 1'b1;
                out_data_next.status       = ST_OK;
                out_data_next.pos_x        = plc_rdata[PLC_W-1:POS_W];
                out_data_next.pos_y        = plc_rdata[POS_W-1:0];
                out_data_next.atlas_side   = chosen_side_reg;
                out_data_next.atlas_height = chosen_height_reg;
                out_data_next.rect_count   = count_reg;
                state_next                 = S_IDLE;
            end

            S_PK_RUN:
            begin
                // read side runs one rectangle ahead of the placement stage
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    wr_idx_next    = rd_idx_reg[IDX_W-1:0];
                    stage_vld_next = 1'b1;
                end
                else
                begin
                    stage_vld_next = 1'b0;
                end

                if (stage_vld_reg)
                begin
                    if (misfit)
                    begin
                        if (side_reg == SIDE_W'(MAX_SIDE))
                        begin
                            emit       = 1'b1;
                            status     = ST_NOFIT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            side_next      = side_reg << 1;
                            rd_idx_next    = '0;
                            stage_vld_next = 1'b0;
                            px_next        = SIDE_W'(1);
                            py_next        = SIDE_W'(1);
                            shelf_next     = '0;
                        end
                    end
                    else
                    begin
                        plc_we     = 1'b1;
                        px_next    = SIDE_W'(px_eff + w_ext + ARITH_W'(1));
                        py_next    = SIDE_W'(py_eff);
                        shelf_next = (h_ext > shelf_eff) ? SIDE_W'(h_ext) : SIDE_W'(shelf_eff);
                    end
                end
                else if (rd_idx_reg == count_reg)
                begin
                    used_next  = py_reg + shelf_reg + SIDE_W'(1);
                    state_next = S_PK_DONE;
                end
            end

            S_PK_DONE:
            begin
                emit               = 1'b1;
                packed_next        = 1'b1;
                chosen_side_next   = side_reg;
                chosen_height_next = (pow < side_reg) ? pow : side_reg;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.status       = status;
            out_data_next.pos_x        = '0;
            out_data_next.pos_y        = '0;
            out_data_next.atlas_side   = chosen_side_next;
            out_data_next.atlas_height = chosen_height_next;
            out_data_next.rect_count   = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            packed_reg        <= 1'b0;
            chosen_side_reg   <= '0;
            chosen_height_reg <= '0;
            side_reg          <= '0;
            rd_idx_reg        <= '0;
            wr_idx_reg        <= '0;
            stage_vld_reg     <= 1'b0;
            px_reg            <= '0;
            py_reg            <= '0;
            shelf_reg         <= '0;
            used_reg          <= '0;
            out_valid_reg     <= 1'b0;
            out_data_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            packed_reg        <= packed_next;
            chosen_side_reg   <= chosen_side_next;
            chosen_height_reg <= chosen_height_next;
            side_reg          <= side_next;
            rd_idx_reg        <= rd_idx_next;
            wr_idx_reg        <= wr_idx_next;
            stage_vld_reg     <= stage_vld_next;
            px_reg            <= px_next;
            py_reg            <= py_next;
            shelf_reg         <= shelf_next;
            used_reg          <= used_next;
            out_valid_reg     <= out_valid_next;
            out_data_reg      <= out_data_next;
        end
    end

    `SAP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_RECTS),
        "rectangle count beyond store depth")
    `SAP_ASSERT_NOW(a_busy_no_result, state_reg != S_IDLE, !out_valid_reg,
        "result pending while a command is still in progress")
    `SAP_ASSERT_NOW(a_pack_consistent, packed_reg,
        chosen_side_reg != '0 && chosen_height_reg <= chosen_side_reg,
        "pack state inconsistent")
    `SAP_ASSERT_NOW(a_stage_in_range, state_reg == S_PK_RUN && stage_vld_reg,
        CNT_W'(wr_idx_reg) < count_reg, "placement write beyond stored rectangles")
    `SAP_ASSERT_NEXT(a_pack_starts, cmd_fire && cmd.data.operation == OP_PACK,
        state_reg == S_PK_RUN && !packed_reg, "pack command did not start a pass")

endmodule
